@@ src/mpfb_pkg.sv @@
// mpfb_pkg: shared types and codes for the page framebuffer blitter
// used by mpfb_ctrl, mpfb_datapath, the top level and the checker
package mpfb_pkg;

  // item kinds on in_action; codes five to seven are ignored
  typedef enum logic [2:0] {
    ACT_BEGIN  = 3'd0,
    ACT_BITMAP = 3'd1,
    ACT_SET    = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH0,
    ST_MERGE0,
    ST_MERGE1,
    ST_READ
  } ctrl_state_t;

  localparam int RowsPerBand = 8;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd0;
    logic wr0;
    logic rd1;
    logic wr1;
    logic rd_host;
    logic clr_step;
    logic res_blit;
    logic res_read;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic blit_active;
    logic two_lanes;
    logic item_blit;
    logic clr_last;
  } dp_status_t;

endpackage

@@ src/monochrome_page_framebuffer_blit.sv @@
// Page-organised 1-bit framebuffer with a byte blitter, SCREEN_WIDTH columns
// by SCREEN_BANDS bands of 8 rows; each byte holds 8 vertical pixels.
// Items enter on in_* with start; a transfer happens when start is high and
// busy is low. Results leave on out_* for exactly one cycle marked by
// out_valid; the receiver cannot stall, so nothing waits on the output side.
// Steps per item, from the transfer until busy drops again:
//   begin, ignored bitmap byte, unused action: none, busy stays low
//   set pixel, bitmap byte in one band or running off screen: fetch, merge
//   bitmap byte straddling two on-screen bands: fetch, merge, merge (two
//   read-modify-writes share the single memory port)
//   read: one memory read, result shown in the cycle after the read issue
//   clear: a sweep of all SCREEN_WIDTH*SCREEN_BANDS bytes (504 by default)
// A bitmap or read result appears in the cycle after the last busy cycle and
// may overlap the next transfer. After reset the block sweeps the memory to
// zero, one byte a cycle, with busy high.
// Depends on mpfb_pkg, mpfb_ctrl and mpfb_datapath.
module monochrome_page_framebuffer_blit #(
  parameter int SCREEN_WIDTH = 84,
  parameter int SCREEN_BANDS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_action,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_blit_width,
  input  logic [7:0] in_blit_height,
  input  logic       in_transparent,
  input  logic [7:0] in_pixel_byte,
  input  logic       in_pixel_value,
  input  logic [8:0] in_read_index,
  output logic       out_valid,
  output logic [7:0] out_read_byte,
  output logic       out_blit_done
);
  import mpfb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  mpfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  // datapath and frame memory
  mpfb_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_BANDS (SCREEN_BANDS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_action      (in_action),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_blit_width  (in_blit_width),
    .in_blit_height (in_blit_height),
    .in_transparent (in_transparent),
    .in_pixel_byte  (in_pixel_byte),
    .in_pixel_value (in_pixel_value),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_read_byte  (out_read_byte),
    .out_blit_done  (out_blit_done)
  );

endmodule

@@ src/mpfb_ctrl.sv @@
// mpfb_ctrl: sequencer for the framebuffer blitter
// steps memory fetch, merge and clearing sweep; depends on mpfb_pkg
module mpfb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2:0]           in_action,
  input  mpfb_pkg::dp_status_t status,
  output logic                 busy,
  output mpfb_pkg::dp_cmd_t    cmd
);
  import mpfb_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // state register, reset starts with a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        if (start) begin
          unique case (in_action)
            ACT_BITMAP: begin
              if (status.blit_active) begin
                state_nxt = ST_FETCH0;
              end
            end
            ACT_SET:   state_nxt = ST_FETCH0;
            ACT_CLEAR: state_nxt = ST_CLEAR;
            ACT_READ:  state_nxt = ST_READ;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FETCH0: begin
        cmd.rd0   = 1'b1;
        state_nxt = ST_MERGE0;
      end
      ST_MERGE0: begin
        cmd.wr0 = 1'b1;
        if (status.two_lanes) begin
          cmd.rd1   = 1'b1;
          state_nxt = ST_MERGE1;
        end else begin
          cmd.res_blit = status.item_blit;
          state_nxt    = ST_IDLE;
        end
      end
      ST_MERGE1: begin
        cmd.wr1      = 1'b1;
        cmd.res_blit = status.item_blit;
        state_nxt    = ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_host  = 1'b1;
        cmd.res_read = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ src/mpfb_datapath.sv @@
// mpfb_datapath: blit state, lane address and mask, frame memory, results
// driven by mpfb_ctrl commands; depends on mpfb_pkg
module mpfb_datapath #(
  parameter int SCREEN_WIDTH = 84,
  parameter int SCREEN_BANDS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpfb_pkg::dp_cmd_t    cmd,
  output mpfb_pkg::dp_status_t status,
  input  logic [2:0]           in_action,
  input  logic [7:0]           in_pos_x,
  input  logic [7:0]           in_pos_y,
  input  logic [7:0]           in_blit_width,
  input  logic [7:0]           in_blit_height,
  input  logic                 in_transparent,
  input  logic [7:0]           in_pixel_byte,
  input  logic                 in_pixel_value,
  input  logic [8:0]           in_read_index,
  output logic                 out_valid,
  output logic [7:0]           out_read_byte,
  output logic                 out_blit_done
);
  import mpfb_pkg::*;

  localparam int Depth = SCREEN_WIDTH * SCREEN_BANDS;
  localparam int AddrW = $clog2(Depth);

  // blit state
  logic [7:0]  origin_x_r, origin_y_r, cursor_dx_r, cursor_dy_r, span_width_r;
  logic [15:0] bytes_left_r;
  logic        transparent_r;

  // latched item
  logic [AddrW-1:0] addr0_r, addr1_r, host_addr_r;
  logic [15:0]      mask_r, data_r;
  logic             lane0_en_r, lane1_en_r, item_blit_r, done_r, rd_ok_r;

  // memory and sweep
  logic [7:0]       mem [Depth];
  logic [7:0]       rd_data_r;
  logic [AddrW-1:0] clr_cnt_r;

  // results
  logic out_valid_r, out_done_r, out_is_read_r;

  logic        is_bitmap, blit_step;
  logic [8:0]  col9, row9;
  logic [5:0]  band0;
  logic [6:0]  band1;
  logic [2:0]  sh;
  logic [7:0]  pat_mask, pat_data;
  logic [15:0] mask16, data16, addr0_full, addr1_full, ri_ext;
  logic        col_ok, band0_ok, band1_ok;
  logic [7:0]  dx_inc;
  logic [12:0] begin_count;

  // lane geometry for the item on the inputs
  always_comb begin
    is_bitmap = (in_action == ACT_BITMAP);
    blit_step = cmd.accept && is_bitmap && (bytes_left_r != 16'd0);
    if (is_bitmap) begin
      col9     = {1'b0, origin_x_r} + {1'b0, cursor_dx_r};
      row9     = {1'b0, origin_y_r} + {1'b0, cursor_dy_r};
      pat_mask = transparent_r ? in_pixel_byte : 8'hFF;
      pat_data = in_pixel_byte;
    end else begin
      col9     = {1'b0, in_pos_x};
      row9     = {1'b0, in_pos_y};
      pat_mask = 8'h01;
      pat_data = {7'd0, in_pixel_value};
    end
    band0      = row9[8:3];
    sh         = row9[2:0];
    band1      = {1'b0, band0} + 7'd1;
    mask16     = {8'h00, pat_mask} << sh;
    data16     = {8'h00, pat_data} << sh;
    col_ok     = col9 < 9'(SCREEN_WIDTH);
    band0_ok   = {1'b0, band0} < 7'(SCREEN_BANDS);
    band1_ok   = band1 < 7'(SCREEN_BANDS);
    addr0_full = 16'(band0) * 16'(SCREEN_WIDTH) + 16'(col9);
    addr1_full = addr0_full + 16'(SCREEN_WIDTH);
    ri_ext     = 16'(in_read_index);
    dx_inc     = cursor_dx_r + 8'd1;
    begin_count = 13'(in_blit_width * 13'(in_blit_height[7:3]));
  end

  // blit state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      cursor_dx_r   <= '0;
      cursor_dy_r   <= '0;
      span_width_r  <= '0;
      bytes_left_r  <= '0;
      transparent_r <= 1'b0;
    end else if (cmd.accept && (in_action == ACT_BEGIN)) begin
      origin_x_r    <= in_pos_x;
      origin_y_r    <= in_pos_y;
      span_width_r  <= in_blit_width;
      transparent_r <= in_transparent;
      cursor_dx_r   <= '0;
      cursor_dy_r   <= '0;
      bytes_left_r  <= 16'(begin_count);
    end else if (blit_step) begin
      if (dx_inc >= span_width_r) begin
        cursor_dx_r <= '0;
        cursor_dy_r <= cursor_dy_r + 8'(RowsPerBand);
      end else begin
        cursor_dx_r <= dx_inc;
      end
      bytes_left_r <= bytes_left_r - 16'd1;
    end
  end

  // latch the item payload on every transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr0_r     <= addr0_full[AddrW-1:0];
      addr1_r     <= addr1_full[AddrW-1:0];
      mask_r      <= mask16;
      data_r      <= data16;
      lane0_en_r  <= col_ok && band0_ok;
      lane1_en_r  <= is_bitmap && (sh != 3'd0) && col_ok && band1_ok;
      item_blit_r <= is_bitmap;
      done_r      <= (bytes_left_r == 16'd1);
      host_addr_r <= ri_ext[AddrW-1:0];
      rd_ok_r     <= ri_ext < 16'(Depth);
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.accept && (in_action == ACT_CLEAR)) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AddrW'(1);
    end
  end

  logic             mem_we, mem_re;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, merge_mask, merge_data;

  // memory port selection and read-modify-write merge
  always_comb begin
    merge_mask = cmd.wr1 ? mask_r[15:8] : mask_r[7:0];
    merge_data = cmd.wr1 ? data_r[15:8] : data_r[7:0];
    mem_we     = cmd.clr_step || (cmd.wr0 && lane0_en_r) || (cmd.wr1 && lane1_en_r);
    priority if (cmd.clr_step) begin
      wr_addr = clr_cnt_r;
      wr_data = 8'h00;
    end else if (cmd.wr1) begin
      wr_addr = addr1_r;
      wr_data = (rd_data_r & ~merge_mask) | (merge_data & merge_mask);
    end else begin
      wr_addr = addr0_r;
      wr_data = (rd_data_r & ~merge_mask) | (merge_data & merge_mask);
    end
    mem_re = cmd.rd0 || cmd.rd1 || (cmd.rd_host && rd_ok_r);
    priority if (cmd.rd1) begin
      rd_addr = addr1_r;
    end else if (cmd.rd_host) begin
      rd_addr = host_addr_r;
    end else begin
      rd_addr = addr0_r;
    end
  end

  // frame memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      out_done_r    <= 1'b0;
      out_is_read_r <= 1'b0;
    end else begin
      out_valid_r   <= cmd.res_blit || cmd.res_read;
      out_done_r    <= cmd.res_blit && done_r;
      out_is_read_r <= cmd.res_read && rd_ok_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blit_done = out_valid_r && out_done_r;
  assign out_read_byte = (out_valid_r && out_is_read_r) ? rd_data_r : 8'h00;

  assign status.blit_active = (bytes_left_r != 16'd0);
  assign status.two_lanes   = lane1_en_r;
  assign status.item_blit   = item_blit_r;
  assign status.clr_last    = (clr_cnt_r == AddrW'(Depth - 1));

endmodule

@@ src/mpfb_checker.sv @@
// mpfb_checker: port-level timing checks for the framebuffer blitter
// bound to monochrome_page_framebuffer_blit; depends on mpfb_pkg
module mpfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_action,
  input logic       out_valid,
  input logic [7:0] out_read_byte,
  input logic       out_blit_done
);
  import mpfb_pkg::*;

  // a read transfer gives its result after the read state, through the registered strobe
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_READ)) |-> ##2 out_valid)
    else $error("read result not on time");

  // a clear transfer starts the sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_CLEAR)) |=> busy)
    else $error("clear did not start sweep");

  // results never come back to back
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in adjacent cycles");

  // result fields are quiet outside a result, and a result with blit done reads zero
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_blit_done) |-> (out_read_byte == 8'h00))
    else $error("read byte not zero");

endmodule

bind monochrome_page_framebuffer_blit mpfb_checker u_mpfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_read_byte (out_read_byte),
  .out_blit_done (out_blit_done)
);

@@ bench/mpfb_frame_checker.sv @@
`timescale 1ns / 100ps
// mpfb_frame_checker: shadow framebuffer and blit cursor built from observed
// input transfers, compared against every result strobe; depends on mpfb_pkg
module mpfb_frame_checker #(
  parameter int SCREEN_WIDTH = 84,
  parameter int SCREEN_BANDS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] in_action,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_blit_width,
  input  logic [7:0] in_blit_height,
  input  logic       in_transparent,
  input  logic [7:0] in_pixel_byte,
  input  logic       in_pixel_value,
  input  logic [8:0] in_read_index,
  input  logic       out_valid,
  input  logic [7:0] out_read_byte,
  input  logic       out_blit_done,
  output int         mismatch_count,
  output int         results_owed
);
  import mpfb_pkg::*;

  localparam int MemDepth = SCREEN_WIDTH * SCREEN_BANDS;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       blit_done;
  } frame_result_t;

  // shadow of the framebuffer and the blit in progress
  logic [7:0]    shadow_frame [MemDepth];
  logic [7:0]    org_x;
  logic [7:0]    org_y;
  logic [7:0]    walk_dx;
  logic [7:0]    walk_dy;
  logic [7:0]    span_cols;
  logic [15:0]   bytes_to_go;
  logic          only_set_bits;
  frame_result_t owed_q [$];

  // one pixel into the shadow frame, off-screen pixels dropped
  task automatic plot_pixel(input int col, input int row, input logic on);
    int idx;
    if (col >= SCREEN_WIDTH || row >= SCREEN_BANDS * RowsPerBand) return;
    idx = (row / RowsPerBand) * SCREEN_WIDTH + col;
    shadow_frame[idx][row % RowsPerBand] = on;
  endtask

  // update the shadow state for one input transfer and queue its result
  task automatic predict_transfer();
    int            col;
    frame_result_t res;
    case (action_t'(in_action))
      ACT_BEGIN: begin
        org_x         = in_pos_x;
        org_y         = in_pos_y;
        span_cols     = in_blit_width;
        only_set_bits = in_transparent;
        walk_dx       = '0;
        walk_dy       = '0;
        bytes_to_go   = 16'(int'(in_blit_width) * (int'(in_blit_height) / RowsPerBand));
      end
      ACT_BITMAP: begin
        // a byte with no blit open is dropped without a result
        if (bytes_to_go != 0) begin
          col = int'(org_x) + int'(walk_dx);
          for (int i = 0; i < RowsPerBand; i++) begin
            if (in_pixel_byte[i] || !only_set_bits)
              plot_pixel(col, int'(org_y) + int'(walk_dy) + i, in_pixel_byte[i]);
          end
          walk_dx = walk_dx + 8'd1;
          if (walk_dx >= span_cols) begin
            walk_dx = '0;
            walk_dy = walk_dy + 8'(RowsPerBand);
          end
          bytes_to_go   = bytes_to_go - 16'd1;
          res.read_byte = '0;
          res.blit_done = (bytes_to_go == 0);
          owed_q.push_back(res);
        end
      end
      ACT_SET: plot_pixel(int'(in_pos_x), int'(in_pos_y), in_pixel_value);
      ACT_CLEAR: begin
        foreach (shadow_frame[k]) shadow_frame[k] = '0;
      end
      ACT_READ: begin
        res.read_byte = (int'(in_read_index) < MemDepth) ? shadow_frame[in_read_index] : '0;
        res.blit_done = 1'b0;
        owed_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // results are compared before the transfer of the same edge is predicted
  always @(posedge clk) begin : frame_watch
    frame_result_t want;
    if (!rst_n) begin
      foreach (shadow_frame[k]) shadow_frame[k] = '0;
      org_x          = '0;
      org_y          = '0;
      walk_dx        = '0;
      walk_dy        = '0;
      span_cols      = '0;
      bytes_to_go    = '0;
      only_set_bits  = 1'b0;
      mismatch_count = 0;
      owed_q.delete();
    end else begin
      if (out_valid) begin
        if (owed_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got byte %h done %b",
                   $time, out_read_byte, out_blit_done);
        end else begin
          want = owed_q.pop_front();
          if (out_read_byte !== want.read_byte) begin
            mismatch_count++;
            $display("%0t: read byte mismatch, expected %h, got %h",
                     $time, want.read_byte, out_read_byte);
          end
          if (out_blit_done !== want.blit_done) begin
            mismatch_count++;
            $display("%0t: blit done mismatch, expected %b, got %b",
                     $time, want.blit_done, out_blit_done);
          end
        end
      end
      if (start && !busy) predict_transfer();
    end
    results_owed = owed_q.size();
  end

endmodule

@@ bench/monochrome_page_framebuffer_blit_tb.sv @@
`timescale 1ns / 100ps
// monochrome_page_framebuffer_blit_tb: clock, reset, stimulus and verdict
// for the page framebuffer blitter; depends on mpfb_pkg and mpfb_frame_checker
module monochrome_page_framebuffer_blit_tb;
  import mpfb_pkg::*;

  localparam int         ScreenWidth    = 84;
  localparam int         ScreenBands    = 6;
  localparam int         ScreenRows     = ScreenBands * RowsPerBand;
  localparam int         MemDepth       = ScreenWidth * ScreenBands;
  localparam int         RandomItems    = 1800;
  localparam int         WatchdogLimit  = 4000;
  localparam int         TailCycles     = 16;
  localparam logic [2:0] ActUnusedFirst = 3'd5;
  localparam logic [2:0] ActUnusedLast  = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_action;
  logic [7:0] in_pos_x;
  logic [7:0] in_pos_y;
  logic [7:0] in_blit_width;
  logic [7:0] in_blit_height;
  logic       in_transparent;
  logic [7:0] in_pixel_byte;
  logic       in_pixel_value;
  logic [8:0] in_read_index;
  logic       out_valid;
  logic [7:0] out_read_byte;
  logic       out_blit_done;

  int mismatch_count;
  int results_owed;
  int idle_cycles = 0;
  int burst_left  = 0;
  int items_done  = 0;

  monochrome_page_framebuffer_blit #(
    .SCREEN_WIDTH(ScreenWidth),
    .SCREEN_BANDS(ScreenBands)
  ) DUT (.*);

  mpfb_frame_checker #(
    .SCREEN_WIDTH(ScreenWidth),
    .SCREEN_BANDS(ScreenBands)
  ) frame_check (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with neither an input transfer nor a result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // fields that the item kind does not use get random values
  task automatic scramble_fields();
    in_pos_x       = 8'($urandom);
    in_pos_y       = 8'($urandom);
    in_blit_width  = 8'($urandom);
    in_blit_height = 8'($urandom);
    in_transparent = 1'($urandom);
    in_pixel_byte  = 8'($urandom);
    in_pixel_value = 1'($urandom);
    in_read_index  = 9'($urandom);
  endtask

  // hold start until the transfer, then sometimes idle for a random gap
  task automatic transfer_item(input logic [2:0] act);
    int gap;
    in_action = act;
    start     = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          burst_left = $urandom_range(10, 40);
          gap        = 0;
        end
        1, 2:                gap = $urandom_range(8, 60);
        3, 4, 5, 6, 7, 8, 9: gap = $urandom_range(1, 3);
        default:             gap = 0;
      endcase
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_begin(input int x, input int y, input int w, input int h,
                            input logic tr);
    scramble_fields();
    in_pos_x       = 8'(x);
    in_pos_y       = 8'(y);
    in_blit_width  = 8'(w);
    in_blit_height = 8'(h);
    in_transparent = tr;
    transfer_item(ACT_BEGIN);
  endtask

  task automatic send_bitmap(input logic [7:0] bits);
    scramble_fields();
    in_pixel_byte = bits;
    transfer_item(ACT_BITMAP);
  endtask

  task automatic send_pixel(input int x, input int y, input logic v);
    scramble_fields();
    in_pos_x       = 8'(x);
    in_pos_y       = 8'(y);
    in_pixel_value = v;
    transfer_item(ACT_SET);
  endtask

  task automatic send_read(input int idx);
    scramble_fields();
    in_read_index = 9'(idx);
    transfer_item(ACT_READ);
  endtask

  task automatic send_other(input logic [2:0] act);
    scramble_fields();
    transfer_item(act);
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_results_done();
    start = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // a byte index near a blit area, taken modulo 512
  function automatic int near_index(input int x, input int y, input int w, input int h);
    int col;
    int row;
    col = x + $urandom_range(0, (w > 0) ? w - 1 : 0);
    row = y + $urandom_range(0, h);
    return ((row / RowsPerBand) * ScreenWidth + col) % 512;
  endfunction

  // one blit with random content, sometimes cut short, reads mixed in
  task automatic blit_sequence();
    int x;
    int y;
    int w;
    int h;
    int total;
    int n;
    x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 90);
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 55);
    w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 10);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(8, 24);
    total = w * (h / RowsPerBand);
    n     = total;
    if (total > 300 || $urandom_range(0, 9) == 0)
      n = (total < 20) ? $urandom_range(0, total) : $urandom_range(0, 20);
    send_begin(x, y, w, h, 1'($urandom));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_read(near_index(x, y, w, h));
        items_done++;
      end
      send_bitmap(8'($urandom));
    end
    items_done += 1 + n;
    if (n == total && total > 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_read(near_index(x, y, w, h));
        items_done++;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int pick;
    rst_n = 1'b0;
    start = 1'b0;
    in_action      = ACT_BEGIN;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_blit_width  = '0;
    in_blit_height = '0;
    in_transparent = 1'b0;
    in_pixel_byte  = '0;
    in_pixel_value = 1'b0;
    in_read_index  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corners, off-screen pixels and reads past the end
    send_read(0);
    send_pixel(0, 0, 1'b1);
    send_pixel(ScreenWidth - 1, ScreenRows - 1, 1'b1);
    send_pixel(ScreenWidth, 5, 1'b1);
    send_pixel(3, ScreenRows, 1'b1);
    send_pixel(255, 255, 1'b1);
    send_read(0);
    send_read(MemDepth - 1);
    send_pixel(ScreenWidth - 1, ScreenRows - 1, 1'b0);
    send_read(511);

    // bitmap bytes with no blit open, zero width and short height
    send_bitmap(8'hff);
    send_begin(0, 0, 0, 16, 1'b0);
    send_bitmap(8'h5a);
    send_begin(5, 0, 4, 7, 1'b0);
    send_bitmap(8'h5a);

    // blit at the bottom right corner, straddling bands and running off screen
    send_begin(ScreenWidth - 2, ScreenRows - 4, 2, 16, 1'b0);
    send_bitmap(8'hff);
    send_bitmap(8'ha5);
    send_bitmap(8'h3c);
    send_bitmap(8'h81);
    send_read(MemDepth - 2);

    // see-through blit straddling two bands
    send_begin(10, 3, 2, 8, 1'b1);
    send_bitmap(8'h81);
    send_bitmap(8'h00);
    send_read(ScreenWidth + 10);

    // largest blit, abandoned by a new begin
    send_begin(0, 0, 255, 255, 1'b0);
    send_bitmap(8'hff);
    send_begin(40, 8, 1, 8, 1'b0);
    send_bitmap(8'h0f);
    send_other(ActUnusedFirst);

    wait_results_done();
    send_other(ACT_CLEAR);
    send_read(0);

    // random traffic, mostly complete blits
    while (items_done < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        blit_sequence();
      end else if (pick < 70) begin
        send_read($urandom_range(0, 511));
        items_done++;
      end else if (pick < 88) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel($urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom));
        else
          send_pixel($urandom_range(0, 90), $urandom_range(0, 55), 1'($urandom));
        items_done++;
      end else if (pick < 94) begin
        send_other(3'($urandom_range(ActUnusedFirst, ActUnusedLast)));
      end else if (pick < 98) begin
        send_bitmap(8'($urandom));
      end else begin
        wait_results_done();
        send_other(ACT_CLEAR);
        items_done++;
      end
    end

    wait_results_done();
    repeat (TailCycles) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
